### hdl/wswt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed tachometer package
// Shared types, register indexes, operation codes and arithmetic constants.
// ----------------------------------------------------------------------------
package wswt_pkg;

	// Field widths.
	localparam int INTERVAL_W = 32;
	localparam int SPEED_W    = 32;
	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	// Default geometry.
	localparam int TEETH_DEFAULT  = 16;
	localparam int WHEELS_DEFAULT = 2;

	// Per-wheel register files are sized for the width of the wheel field.
	localparam int WHEEL_SLOTS = 2;

	// Numerator of the speed conversion: 60e9 needs 36 bits.
	localparam int NUM_W = 36;
	localparam logic [NUM_W-1:0] MRPM_NUM = 36'd60000000000;

	// Divisor width for the default geometry: interval * 2 * teeth.
	localparam int DEN_W_DEFAULT = INTERVAL_W + $clog2(2 * TEETH_DEFAULT);

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD_MS = 2'd1;
	localparam logic [CFG_W-1:0]     TIMEOUT_RESET      = 16'd100;
	localparam logic [CFG_W-1:0]     READ_PERIOD_RESET  = 16'd10;

	// Operation codes of an input item.
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic                  operation;
		logic                  wheel;
		logic [INTERVAL_W-1:0] interval_us;
		logic [TIME_W-1:0]     now_ms;
	} item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] left_speed_mrpm;
		logic [SPEED_W-1:0] right_speed_mrpm;
		logic               recomputed;
	} result_t;

endpackage

### hdl/wswt_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tooth interval ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wswt_ring #(
	parameter int DEPTH = wswt_pkg::WHEELS_DEFAULT * wswt_pkg::TEETH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [$clog2(DEPTH)-1:0]           wr_addr,
	input  logic [wswt_pkg::INTERVAL_W-1:0]    wr_data,
	input  logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic [wswt_pkg::INTERVAL_W-1:0]    rd_data
);
	import wswt_pkg::*;

	logic [INTERVAL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data available in the cycle after the address.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/wswt_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wswt_serial_div #(
	parameter int DEN_W = wswt_pkg::DEN_W_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wswt_pkg::NUM_W-1:0]   dividend,
	input  logic [DEN_W-1:0]             divisor,
	output logic                         busy,
	output logic                         done,
	output logic [wswt_pkg::NUM_W-1:0]   quotient
);
	import wswt_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign fits    = ~diff[DEN_W+1];

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath shift registers.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hdl/wheel_speed_weighted_tachometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel speed weighted tachometer
// Tooth-edge tachometer for up to two wheels with a linearly weighted
// moving average of the tooth intervals and a milli-RPM conversion.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Direction  Transfer when
//  item      item_valid, item_stall, item     in         valid & !stall
//  result    result_valid, result_stall, res  out        valid & !stall
//  cfg       cfg_valid, cfg_ready, cfg_index  in         valid & ready
//
// A capture passes ST_CAP_RD, ST_CAP_A and ST_CAP_B before the next item is taken.
// A read that is not yet due passes ST_RD_CHECK and presents its result in ST_OUT.
// A recompute runs up to two divisions per wheel on the bit-serial divider,
// one for the weighted average and one for the milli-RPM conversion, before
// it presents its result once the output register is free.
// Reset restores all sums, counts and speeds to zero and the registers to
// their defaults. A stalled result is held in the output register while
// further captures are taken; a later read waits for it to be taken.
//
module wheel_speed_weighted_tachometer #(
	parameter int TEETH  = wswt_pkg::TEETH_DEFAULT,
	parameter int WHEELS = wswt_pkg::WHEELS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  wswt_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output wswt_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wswt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wswt_pkg::CFG_W-1:0]        cfg_data
);
	import wswt_pkg::*;

	localparam int DEPTH        = WHEELS * TEETH;
	localparam int AW           = $clog2(DEPTH);
	localparam int SLOT_W       = $clog2(TEETH);
	localparam int DEN_W        = INTERVAL_W + $clog2(2 * TEETH);
	localparam int WEIGHT_TOTAL = TEETH * (TEETH + 1) / 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAP_RD,
		ST_CAP_A,
		ST_CAP_B,
		ST_RD_CHECK,
		ST_RD_WHEEL,
		ST_RD_RING,
		ST_RD_AVG,
		ST_RD_MUL,
		ST_RD_CONV,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] period_q;

	// Per-wheel state.
	logic [TIME_W-1:0]     count_q     [WHEEL_SLOTS];
	logic [SLOT_W-1:0]     slot_q      [WHEEL_SLOTS];
	logic [INTERVAL_W-1:0] wsum_q      [WHEEL_SLOTS];
	logic [INTERVAL_W-1:0] win_q       [WHEEL_SLOTS];
	logic [TIME_W-1:0]     last_edge_q [WHEEL_SLOTS];
	logic [SPEED_W-1:0]    speed_q     [WHEEL_SLOTS];
	logic                  written_q   [WHEEL_SLOTS];
	logic                  stopped_q   [WHEEL_SLOTS];
	logic [TIME_W-1:0]     last_read_q;

	// Item holding registers and working values.
	logic                  wheel_q;
	logic [INTERVAL_W-1:0] iv_q;
	logic [TIME_W-1:0]     now_q;
	logic [INTERVAL_W-1:0] prod_q;
	logic [INTERVAL_W-1:0] tmp_q;
	logic [INTERVAL_W-1:0] part_q;
	logic [INTERVAL_W-1:0] iv_sel_q;
	logic                  wsel_q;
	logic                  recomp_q;
	logic                  result_valid_q;
	result_t               result_q;

	// Divider operands.
	logic             div_start_q;
	logic [NUM_W-1:0] div_num_q;
	logic [DEN_W-1:0] div_den_q;
	logic             div_busy;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	// Ring ports.
	logic                  ring_wr_en;
	logic [AW-1:0]         ring_wr_addr;
	logic [AW-1:0]         ring_rd_addr;
	logic [AW-1:0]         cap_addr;
	logic [AW-1:0]         read_addr;
	logic [SLOT_W-1:0]     prev_slot;
	logic [INTERVAL_W-1:0] ring_rd_data;
	logic [INTERVAL_W-1:0] oldest;

	logic item_take;
	logic wheel_ok;
	logic last_wheel;
	logic read_due;
	logic timed_out;
	logic ring_full_cap;
	logic ring_full_rd;

	// Handshakes.
	assign item_stall   = (state_q != ST_IDLE);
	assign item_take    = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign wheel_ok   = (32'(item.wheel) < 32'(WHEELS));
	assign last_wheel = (wsel_q == 1'(WHEELS - 1));

	// Time comparisons on wrapped sums.
	assign read_due  = (last_read_q + {16'b0, period_q}) < now_q;
	assign timed_out = (last_edge_q[wsel_q] + {16'b0, timeout_q}) < now_q;

	assign ring_full_cap = (count_q[wheel_q] >= 32'(TEETH));
	assign ring_full_rd  = (count_q[wsel_q] >= 32'(TEETH));

	// Slot of the newest entry of the wheel being read.
	always_comb begin
		if (count_q[wsel_q] == '0) begin
			prev_slot = '0;
		end else if (slot_q[wsel_q] == '0) begin
			prev_slot = SLOT_W'(TEETH - 1);
		end else begin
			prev_slot = slot_q[wsel_q] - 1'b1;
		end
	end

	// Ring addressing: each wheel owns TEETH consecutive entries.
	assign cap_addr  = AW'(slot_q[wheel_q]) + (wheel_q ? AW'(TEETH) : '0);
	assign read_addr = AW'(prev_slot) + (wsel_q ? AW'(TEETH) : '0);

	assign ring_wr_en   = (state_q == ST_CAP_B);
	assign ring_wr_addr = cap_addr;
	assign ring_rd_addr = (state_q == ST_CAP_RD) ? cap_addr : read_addr;
	assign oldest       = ring_full_cap ? ring_rd_data : '0;

	wswt_ring #(
		.DEPTH(DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (ring_wr_en),
		.wr_addr(ring_wr_addr),
		.wr_data(iv_q),
		.rd_addr(ring_rd_addr),
		.rd_data(ring_rd_data)
	);

	wswt_serial_div #(
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(div_num_q),
		.divisor (div_den_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			period_q  <= READ_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_TIMEOUT_MS) begin
				timeout_q <= cfg_data;
			end
			if (cfg_index == REG_READ_PERIOD_MS) begin
				period_q <= cfg_data;
			end
		end
	end

	// Sequencer with the wheel state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_read_q    <= '0;
			wheel_q        <= 1'b0;
			iv_q           <= '0;
			now_q          <= '0;
			prod_q         <= '0;
			tmp_q          <= '0;
			part_q         <= '0;
			iv_sel_q       <= '0;
			wsel_q         <= 1'b0;
			recomp_q       <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			div_start_q    <= 1'b0;
			div_num_q      <= '0;
			div_den_q      <= '0;
			for (int w = 0; w < WHEEL_SLOTS; w++) begin
				count_q[w]     <= '0;
				slot_q[w]      <= '0;
				wsum_q[w]      <= '0;
				win_q[w]       <= '0;
				last_edge_q[w] <= '0;
				speed_q[w]     <= '0;
				written_q[w]   <= 1'b0;
				stopped_q[w]   <= 1'b0;
			end
		end else begin
			div_start_q <= 1'b0;
			// The result stage reloads the register itself when it is free.
			if (result_valid_q && !result_stall && state_q != ST_OUT) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						wheel_q <= item.wheel;
						iv_q    <= item.interval_us;
						now_q   <= item.now_ms;
						if (item.operation == OP_READ) begin
							state_q <= ST_RD_CHECK;
						end else if (wheel_ok) begin
							state_q <= ST_CAP_RD;
						end
					end
				end

				// Capture: ring read of the oldest entry, scaled interval.
				ST_CAP_RD: begin
					prod_q  <= iv_q * INTERVAL_W'(TEETH);
					state_q <= ST_CAP_A;
				end

				ST_CAP_A: begin
					tmp_q   <= prod_q - win_q[wheel_q];
					part_q  <= iv_q - oldest;
					state_q <= ST_CAP_B;
				end

				// Capture: commit sums, count, slot, edge time and ring entry.
				ST_CAP_B: begin
					wsum_q[wheel_q]      <= wsum_q[wheel_q] + tmp_q;
					win_q[wheel_q]       <= win_q[wheel_q] + part_q;
					count_q[wheel_q]     <= count_q[wheel_q] + 1'b1;
					last_edge_q[wheel_q] <= now_q;
					written_q[wheel_q]   <= 1'b1;
					if (count_q[wheel_q] == '1 ||
						slot_q[wheel_q] == SLOT_W'(TEETH - 1)) begin
						slot_q[wheel_q] <= '0;
					end else begin
						slot_q[wheel_q] <= slot_q[wheel_q] + 1'b1;
					end
					state_q <= ST_IDLE;
				end

				ST_RD_CHECK: begin
					recomp_q <= read_due;
					wsel_q   <= 1'b0;
					if (read_due) begin
						last_read_q <= now_q;
						state_q     <= ST_RD_WHEEL;
					end else begin
						state_q <= ST_OUT;
					end
				end

				// Pick the interval source for one wheel, or zero a timed-out wheel.
				ST_RD_WHEEL: begin
					stopped_q[wsel_q] <= timed_out;
					if (timed_out) begin
						speed_q[wsel_q] <= '0;
						wsel_q          <= wsel_q + 1'b1;
						state_q         <= last_wheel ? ST_OUT : ST_RD_WHEEL;
					end else if (!ring_full_rd) begin
						state_q <= ST_RD_RING;
					end else begin
						div_num_q   <= NUM_W'(wsum_q[wsel_q]);
						div_den_q   <= DEN_W'(WEIGHT_TOTAL);
						div_start_q <= 1'b1;
						state_q     <= ST_RD_AVG;
					end
				end

				ST_RD_RING: begin
					iv_sel_q <= written_q[wsel_q] ? ring_rd_data : '0;
					state_q  <= ST_RD_MUL;
				end

				ST_RD_AVG: begin
					if (div_done) begin
						iv_sel_q <= div_quo[INTERVAL_W-1:0];
						state_q  <= ST_RD_MUL;
					end
				end

				// Scale the interval into the conversion divisor; a zero interval gives zero speed.
				ST_RD_MUL: begin
					if (iv_sel_q == '0) begin
						speed_q[wsel_q] <= '0;
						wsel_q          <= wsel_q + 1'b1;
						state_q         <= last_wheel ? ST_OUT : ST_RD_WHEEL;
					end else begin
						div_num_q   <= MRPM_NUM;
						div_den_q   <= DEN_W'(iv_sel_q) * DEN_W'(2 * TEETH);
						div_start_q <= 1'b1;
						state_q     <= ST_RD_CONV;
					end
				end

				// Saturate the quotient into the speed register.
				ST_RD_CONV: begin
					if (div_done) begin
						speed_q[wsel_q] <= (|div_quo[NUM_W-1:SPEED_W]) ? '1 :
							div_quo[SPEED_W-1:0];
						wsel_q  <= wsel_q + 1'b1;
						state_q <= last_wheel ? ST_OUT : ST_RD_WHEEL;
					end
				end

				// With a single wheel the right speed reads as zero.
				ST_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.left_speed_mrpm  <= speed_q[0];
						result_q.right_speed_mrpm <= (WHEELS > 1) ? speed_q[1] : '0;
						result_q.recomputed       <= recomp_q;
						result_valid_q            <= 1'b1;
						state_q                   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The divider is never left running while new items are taken.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !div_busy)
		else $error("divider busy while items are accepted");

	// A result only appears from the result stage of a read.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the result stage");

	// A wheel marked stopped always reads as zero speed.
	a_stopped_left: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q[0] |-> (speed_q[0] == '0))
		else $error("stopped left wheel has nonzero speed");

	a_stopped_right: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q[1] |-> (speed_q[1] == '0))
		else $error("stopped right wheel has nonzero speed");
`endif

endmodule

### sim/wswt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tachometer result checker
// Watches the item, result and register channels of the tachometer. It keeps
// its own copy of the tooth rings, sums and registers, works out the speed
// report that each read must produce, and compares every report field by
// field with the oldest one still due.
// ----------------------------------------------------------------------------
module wswt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  wswt_pkg::item_t                item,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  wswt_pkg::result_t              result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [wswt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wswt_pkg::CFG_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             captures_seen,
	output int                             reads_seen,
	output int                             recomputes_seen
);
	import wswt_pkg::*;

	localparam logic [31:0] TEETH_N      = TEETH_DEFAULT;
	localparam logic [31:0] WEIGHT_TOTAL = TEETH_N * (TEETH_N + 32'd1) / 32'd2;
	localparam logic [63:0] MRPM_SCALE   = 64'd60000000000;

	// Shadow of the block's registers and per-wheel state.
	logic [CFG_W-1:0] timeout_reg;
	logic [CFG_W-1:0] period_reg;
	logic [31:0]      ring [WHEEL_SLOTS][TEETH_DEFAULT];
	logic [31:0]      edge_cnt [WHEEL_SLOTS];
	logic [31:0]      weighted [WHEEL_SLOTS];
	logic [31:0]      window [WHEEL_SLOTS];
	logic [31:0]      last_edge [WHEEL_SLOTS];
	logic [31:0]      speed [WHEEL_SLOTS];
	logic [31:0]      last_read;

	// Speed reports still owed by the block, oldest first.
	result_t due_reports [$];

	int err_total;
	int captures_n;
	int reads_n;
	int recomputes_n;

	// Prints one line per mismatch and counts it.
	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_total++;
	endtask

	// Converts a tooth interval in microseconds to milli-RPM.
	function automatic logic [31:0] to_mrpm(input logic [31:0] interval);
		logic [63:0] divisor;
		logic [63:0] quotient;
		if (interval == 32'd0)
			return 32'd0;
		divisor  = {32'd0, interval} * {32'd0, TEETH_N} * 64'd2;
		quotient = MRPM_SCALE / divisor;
		return (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
	endfunction

	function automatic void clear_state();
		timeout_reg = TIMEOUT_RESET;
		period_reg  = READ_PERIOD_RESET;
		last_read   = '0;
		for (int w = 0; w < WHEEL_SLOTS; w++) begin
			edge_cnt[w]  = '0;
			weighted[w]  = '0;
			window[w]    = '0;
			last_edge[w] = '0;
			speed[w]     = '0;
			for (int t = 0; t < TEETH_DEFAULT; t++)
				ring[w][t] = '0;
		end
		due_reports.delete();
	endfunction

	// A tooth edge: store the interval and slide both sums by one tooth.
	function automatic void apply_capture(input logic w, input logic [31:0] interval,
			input logic [31:0] stamp);
		logic [31:0] cnt;
		logic [31:0] slot;
		logic [31:0] oldest;
		cnt    = edge_cnt[w];
		slot   = cnt % TEETH_N;
		oldest = (cnt < TEETH_N) ? 32'd0 : ring[w][slot];
		ring[w][slot] = interval;
		edge_cnt[w]   = cnt + 32'd1;
		weighted[w]   = weighted[w] + TEETH_N * interval - window[w];
		window[w]     = window[w] + interval - oldest;
		last_edge[w]  = stamp;
	endfunction

	// Recomputes both wheel speeds at the given tick.
	function automatic void recompute_speeds(input logic [31:0] stamp);
		logic [31:0] cnt;
		logic [31:0] slot;
		logic [31:0] deadline;
		last_read = stamp;
		for (int w = 0; w < WHEEL_SLOTS; w++) begin
			cnt      = edge_cnt[w];
			slot     = (cnt > 32'd0) ? (cnt - 32'd1) % TEETH_N : 32'd0;
			deadline = last_edge[w] + {16'd0, timeout_reg};
			if (deadline < stamp)
				speed[w] = '0;
			else if (cnt < TEETH_N)
				speed[w] = to_mrpm(ring[w][slot]);
			else
				speed[w] = to_mrpm(weighted[w] / WEIGHT_TOTAL);
		end
	endfunction

	// Updates the shadow state for one accepted item and queues any report.
	function automatic void predict_item(input item_t it);
		result_t     want;
		logic [31:0] due_at;
		if (it.operation == OP_CAPTURE) begin
			apply_capture(it.wheel, it.interval_us, it.now_ms);
			captures_n++;
			return;
		end
		reads_n++;
		due_at = last_read + {16'd0, period_reg};
		want.recomputed = 1'b0;
		if (due_at < it.now_ms) begin
			recompute_speeds(it.now_ms);
			want.recomputed = 1'b1;
			recomputes_n++;
		end
		want.left_speed_mrpm  = speed[0];
		want.right_speed_mrpm = speed[1];
		due_reports.push_back(want);
	endfunction

	task automatic check_report(input result_t got);
		result_t want;
		if (due_reports.size() == 0) begin
			report_error($sformatf("report with no read outstanding: %h", got));
			return;
		end
		want = due_reports.pop_front();
		if (got.left_speed_mrpm !== want.left_speed_mrpm)
			report_error($sformatf("left speed %0d, expected %0d",
				got.left_speed_mrpm, want.left_speed_mrpm));
		if (got.right_speed_mrpm !== want.right_speed_mrpm)
			report_error($sformatf("right speed %0d, expected %0d",
				got.right_speed_mrpm, want.right_speed_mrpm));
		if (got.recomputed !== want.recomputed)
			report_error($sformatf("recomputed flag %b, expected %b",
				got.recomputed, want.recomputed));
	endtask

	// Sample every channel at the clock edge and publish the counts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			fail_count      <= 0;
			pending         <= 0;
			captures_seen   <= 0;
			reads_seen      <= 0;
			recomputes_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT_MS:     timeout_reg = cfg_data;
					REG_READ_PERIOD_MS: period_reg  = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall)
				check_report(result);
			if (item_valid && !item_stall)
				predict_item(item);
			fail_count      <= err_total;
			pending         <= due_reports.size();
			captures_seen   <= captures_n;
			reads_seen      <= reads_n;
			recomputes_seen <= recomputes_n;
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tachometer testbench
// Drives tooth captures and speed reads into the tachometer under several
// register settings, with random gaps on both channels and one long hold-off
// on the result side. A separate checker predicts and compares the reports.
// ----------------------------------------------------------------------------
module tb_top;
	import wswt_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 1000;
	localparam int PHASE_ITEMS  = 125;

	localparam logic WHEEL_LEFT  = 1'b0;
	localparam logic WHEEL_RIGHT = 1'b1;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int captures_seen;
	int reads_seen;
	int recomputes_seen;

	// Shared stimulus controls.
	int          idle_max     = 10;
	logic        hold_request = 1'b0;
	int          settings_n   = 1;
	int          quiet_cycles = 0;
	logic [31:0] clock_ms     = '0;

	wheel_speed_weighted_tachometer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	wswt_checker tach_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.captures_seen   (captures_seen),
		.reads_seen      (reads_seen),
		.recomputes_seen (recomputes_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one item after a random gap and waits for its transfer.
	task automatic offer(input logic op, input logic w, input logic [31:0] interval,
			input logic [31:0] stamp);
		item_t pkt;
		int    gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt.operation   = op;
		pkt.wheel       = w;
		pkt.interval_us = interval;
		pkt.now_ms      = stamp;
		item       <= pkt;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
	endtask

	// Lets every owed report arrive, then lets the block settle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One random item; the tick mostly moves forward in small steps.
	task automatic random_item(input int step_ms);
		int          pick;
		int          sel;
		logic [31:0] interval;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 19);
		clock_ms += $urandom_range(0, step_ms);
		if ($urandom_range(0, 49) == 0)
			clock_ms += $urandom_range(0, 70000);
		if (sel == 0)
			interval = 32'd0;
		else if (sel == 1)
			interval = 32'd1;
		else if (sel == 2)
			interval = 32'hFFFF_FFFF;
		else if (sel < 5)
			interval = $urandom;
		else
			interval = $urandom_range(200, 60000);
		if (pick < 60)
			offer(OP_CAPTURE, 1'($urandom), interval, clock_ms);
		else if (pick < 95)
			offer(OP_READ, 1'($urandom), $urandom, clock_ms);
		else
			// Capture with a stray timestamp, unrelated to the running tick.
			offer(OP_CAPTURE, 1'($urandom), interval, $urandom);
	endtask

	// Rewrites both registers while idle, then runs a block of random items.
	task automatic run_phase(input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] per,
			input int idle, input int step_ms, input logic hold);
		drain();
		cfg_index <= REG_TIMEOUT_MS;
		cfg_data  <= tmo;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_index <= REG_READ_PERIOD_MS;
		cfg_data  <= per;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		settings_n++;
		idle_max     = idle;
		hold_request = hold;
		repeat (PHASE_ITEMS) random_item(step_ms);
	endtask

	// Result side: random stall before each report, one long hold on request.
	initial begin : result_sink
		int   gap;
		logic hold_taken;
		hold_taken = 1'b0;
		result_stall <= 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request && !hold_taken) begin
				gap = HOLD_CYCLES;
				hold_taken = 1'b1;
			end else begin
				gap = $urandom_range(0, idle_max);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid === 1'b1 && !result_stall));
		end
	end

	// Ends the run when no channel has made a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("No transfer on any channel for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main stimulus.
	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_TIMEOUT_MS;
		cfg_data   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values.
		// Read before the period has passed, then the first recompute with no edges.
		offer(OP_READ, WHEEL_RIGHT, 32'hFFFF_FFFF, 32'd0);
		offer(OP_READ, WHEEL_LEFT, 32'd0, 32'd11);
		// Interval extremes on both wheels.
		offer(OP_CAPTURE, WHEEL_LEFT, 32'd0, 32'd12);
		offer(OP_CAPTURE, WHEEL_RIGHT, 32'hFFFF_FFFF, 32'd12);
		offer(OP_READ, WHEEL_LEFT, 32'd0, 32'd22);
		// Shortest nonzero interval gives the fastest speed.
		offer(OP_CAPTURE, WHEEL_LEFT, 32'd1, 32'd23);
		offer(OP_READ, WHEEL_RIGHT, 32'd5, 32'd30);
		offer(OP_READ, WHEEL_LEFT, 32'd7, 32'd33);
		// Fill and wrap the left ring so the weighted average takes over.
		repeat (15) offer(OP_CAPTURE, WHEEL_LEFT, $urandom_range(500, 5000), 32'd40);
		offer(OP_READ, WHEEL_RIGHT, $urandom, 32'd50);
		// Both wheels time out.
		offer(OP_READ, WHEEL_LEFT, $urandom, 32'd250);
		clock_ms = 32'd250;

		// Random part over several register settings.
		run_phase(16'hFFFF, 16'd0, 10, 3, 1'b0);
		run_phase(16'd20, 16'd5, 0, 4, 1'b1);
		run_phase(16'($urandom), 16'($urandom_range(0, 20)), 10, 3, 1'b0);
		run_phase(16'd0, 16'hFFFF, 10, 3000, 1'b0);
		// The tick is set near the top of its 32-bit range here.
		clock_ms = 32'hFFF0_0000;
		run_phase(16'd5000, 16'hFFFF, 10, 3000, 1'b0);

		drain();
		$display("Covered %0d captures and %0d reads, %0d of which recomputed the speeds,",
			captures_seen, reads_seen, recomputes_seen);
		$display("over %0d register settings, with one long hold-off on the reports.",
			settings_n);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
hdl/wswt_pkg.sv
hdl/wswt_ring.sv
hdl/wswt_serial_div.sv
hdl/wheel_speed_weighted_tachometer.sv
sim/wswt_checker.sv
sim/tb_top.sv
